@@ sv/gcws_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gap-constrained weight selection block.
// No dependencies.
package gcws_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int VALUE_BITS = 32;
  localparam int SPAN_BITS  = 8;
  localparam int TOTAL_BITS = 42;
  localparam int OUT_BYTES_BITS = 48;

  localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(2);

  // One entry of the sorted value table
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [CNT_BITS-1:0]   count;
  } vc_t;

  localparam int VC_BITS = VALUE_BITS + CNT_BITS;

endpackage

@@ sv/gcws_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gcws_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/gap_constrained_weight_selection.sv @@
`timescale 1ns / 1ps
// Top level: sorted value/count table, insertion sequencer and selection pass.
// Depends on gcws_pkg and gcws_ram.
//
// Usage:
//   Values stream in on the s_axis group, one per transaction; s_axis_tlast
//   marks the final value of a set. Each value is inserted into a sorted
//   table of distinct values held in RAM (a repeat only bumps its count).
//   Insertion scans the table from the top entry down, then shifts larger
//   entries up one slot. After the last item a backward pass over the table
//   computes the best total, with a conflict pointer that marks the first
//   entry beyond the conflict span, and one transaction on m_axis carries it,
//   with the overflow flag in m_axis_tuser. Items beyond 1024 per set are
//   dropped.
//   One item is worked on at a time; s_axis_tready is high only while idle.
//   The result sits in an output register, so the next set can load while
//   the receiver stalls; a second result waits until the first is taken.
//   cfg_we writes conflict_span (reset 2); write it only while idle.
//   rst (synchronous) empties the set and drops any pending result.
module gap_constrained_weight_selection (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [41:0] best_total, upper bits zero
  output logic        m_axis_tuser,   // overflow
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata       // conflict_span
);

  localparam int AB = gcws_pkg::ADDR_BITS;
  localparam int CB = gcws_pkg::CNT_BITS;
  localparam int VB = gcws_pkg::VALUE_BITS;
  localparam int TB = gcws_pkg::TOTAL_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCMP, S_SHIFT, S_SWR, S_PSTART, S_RD_E, S_GOT_E,
    S_JCHK, S_JCMP, S_BEST, S_SUM, S_DONE
  } state_t;

  state_t state;

  logic [CB-1:0] distinct_used, items_seen, idx, pos, jp;
  logic          overflow_seen, last_pend;
  logic [gcws_pkg::SPAN_BITS-1:0] span;
  logic [VB-1:0] v_in, ve;
  logic [CB-1:0] ce;
  logic [VB:0]   limit;
  logic [TB-1:0] prod, prev_best, out_total, best_new, take, skip;
  logic          out_valid, out_ovf;

  // RAM ports
  gcws_pkg::vc_t vc_rd, vc_wdata;
  logic          vc_we;
  logic [AB-1:0] vc_waddr, vc_raddr;
  logic          best_we;
  logic [AB-1:0] best_waddr, best_raddr;
  logic [TB-1:0] best_rd;

  logic [CB-1:0] idx_m1, jp_m1, idx_p1;
  logic          in_acc, out_free;

  assign idx_m1 = idx - CB'(1);
  assign idx_p1 = idx + CB'(1);
  assign jp_m1  = jp - CB'(1);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  gcws_ram #(.WIDTH(gcws_pkg::VC_BITS), .ADDR_BITS(AB)) u_vc_ram (
    .clk(clk), .we(vc_we), .waddr(vc_waddr), .wdata(vc_wdata),
    .raddr(vc_raddr), .rdata(vc_rd)
  );

  gcws_ram #(.WIDTH(TB), .ADDR_BITS(AB)) u_best_ram (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_new),
    .raddr(best_raddr), .rdata(best_rd)
  );

  // Selection step: take this entry plus best past the conflict window, or skip
  assign take     = TB'(prod + ((jp < distinct_used) ? best_rd : TB'(0)));
  assign skip     = (idx_p1 < distinct_used) ? prev_best : TB'(0);
  assign best_new = (take > skip) ? take : skip;

  // RAM addressing per state
  always_comb begin
    vc_we      = 1'b0;
    vc_waddr   = idx[AB-1:0];
    vc_wdata   = vc_rd;
    vc_raddr   = idx_m1[AB-1:0];
    best_we    = 1'b0;
    best_waddr = idx[AB-1:0];
    best_raddr = jp[AB-1:0];
    case (state)
      S_SCMP: begin
        if (vc_rd.value == v_in) begin
          vc_we    = 1'b1;
          vc_waddr = idx_m1[AB-1:0];
          vc_wdata = '{value: vc_rd.value, count: vc_rd.count + CB'(1)};
        end
      end
      S_SHIFT: begin
        if (idx == pos) begin
          vc_we    = 1'b1;
          vc_waddr = pos[AB-1:0];
          vc_wdata = '{value: v_in, count: CB'(1)};
        end
      end
      S_SWR: begin
        vc_we = 1'b1;
      end
      S_RD_E: begin
        vc_raddr = idx[AB-1:0];
      end
      S_JCHK: begin
        vc_raddr = jp_m1[AB-1:0];
      end
      S_SUM: begin
        best_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(48 - TB){1'b0}}, out_total};
  assign m_axis_tuser  = out_ovf;

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      distinct_used <= '0;
      items_seen    <= '0;
      overflow_seen <= 1'b0;
      span          <= gcws_pkg::SPAN_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        span <= cfg_wdata;
      end
      // Output register drains; S_DONE handles it while a result is loaded
      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            v_in      <= s_axis_tdata;
            last_pend <= s_axis_tlast;
            if (items_seen >= CB'(gcws_pkg::MAX_ITEMS)) begin
              overflow_seen <= 1'b1;
              state <= s_axis_tlast ? S_PSTART : S_IDLE;
            end else begin
              items_seen <= items_seen + CB'(1);
              idx        <= distinct_used;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == '0) begin
            pos   <= '0;
            idx   <= distinct_used;
            state <= S_SHIFT;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (vc_rd.value > v_in) begin
            idx   <= idx_m1;
            state <= S_SCAN;
          end else if (vc_rd.value == v_in) begin
            state <= last_pend ? S_PSTART : S_IDLE;
          end else begin
            pos   <= idx;
            idx   <= distinct_used;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx == pos) begin
            distinct_used <= distinct_used + CB'(1);
            state <= last_pend ? S_PSTART : S_IDLE;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          idx   <= idx_m1;
          state <= S_SHIFT;
        end
        S_PSTART: begin
          jp <= distinct_used;
          if (distinct_used == '0) begin
            prev_best <= '0;
            state     <= S_DONE;
          end else begin
            idx   <= distinct_used - CB'(1);
            state <= S_RD_E;
          end
        end
        S_RD_E: begin
          state <= S_GOT_E;
        end
        S_GOT_E: begin
          ve    <= vc_rd.value;
          ce    <= vc_rd.count;
          limit <= {1'b0, vc_rd.value} + (VB + 1)'(span);
          state <= S_JCHK;
        end
        S_JCHK: begin
          state <= (jp > idx_p1) ? S_JCMP : S_BEST;
        end
        S_JCMP: begin
          if ({1'b0, vc_rd.value} > limit) begin
            jp    <= jp_m1;
            state <= S_JCHK;
          end else begin
            state <= S_BEST;
          end
        end
        S_BEST: begin
          prod  <= TB'(ve) * TB'(ce);
          state <= S_SUM;
        end
        S_SUM: begin
          prev_best <= best_new;
          if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx   <= idx_m1;
            state <= S_RD_E;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_total     <= prev_best;
            out_ovf       <= overflow_seen;
            distinct_used <= '0;
            items_seen    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Table never holds more distinct values than items taken
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    distinct_used <= items_seen) else $error("distinct count exceeds items");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    items_seen <= CB'(gcws_pkg::MAX_ITEMS)) else $error("item count beyond capacity");

  // Conflict pointer always stays above the entry being solved
  a_jp: assert property (@(posedge clk) disable iff (rst)
    (state == S_JCHK || state == S_BEST || state == S_SUM) |-> (jp > idx))
    else $error("conflict pointer below current entry");

  // A result is only loaded when the output register is free
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !m_axis_tready) |=> (state == S_DONE))
    else $error("result overwritten while stalled");
`endif

endmodule

@@ dv/tb_gap_constrained_weight_selection.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gap_constrained_weight_selection: directed sets and
// random sets over several conflict spans, checked against a built-in predictor.
// Depends on gcws_pkg and the block's RTL.
module tb_gap_constrained_weight_selection;

  typedef struct {
    logic [gcws_pkg::VALUE_BITS-1:0] value;
    logic                            last;
    logic                            typed;      // expected result typed in below
    logic [gcws_pkg::TOTAL_BITS-1:0] total;
    logic                            ovf;
  } stim_row_t;

  typedef struct {
    logic [gcws_pkg::TOTAL_BITS-1:0] total;
    logic                            ovf;
  } selection_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  // Predictor state
  logic [gcws_pkg::VALUE_BITS-1:0] set_values[$];
  int unsigned                     set_counts[$];
  int unsigned                     set_items;
  logic                            set_dropped;
  logic [gcws_pkg::SPAN_BITS-1:0]  span_now;
  selection_t                      pending_totals[$];

  int unsigned fail_count;
  bit          quiet;      // no idling on either side
  bit          hold_req;   // receiver holds off for a long stretch

  gap_constrained_weight_selection i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Best total over the collected set, bottom-up from the highest value
  function automatic logic [gcws_pkg::TOTAL_BITS-1:0] best_selection();
    longint unsigned best[0:gcws_pkg::MAX_ITEMS];
    longint unsigned bound;
    longint unsigned take;
    int n;
    int j;
    n = set_values.size();
    best[n] = 0;
    for (int e = n - 1; e >= 0; e--) begin
      bound = longint'(set_values[e]) + longint'(span_now);
      j = e + 1;
      while (j < n && longint'(set_values[j]) <= bound) j++;
      take = longint'(set_values[e]) * longint'(set_counts[e]) + best[j];
      best[e] = (take > best[e + 1]) ? take : best[e + 1];
    end
    return best[0][gcws_pkg::TOTAL_BITS-1:0];
  endfunction

  // Fold one accepted value into the set; returns 1 with a result on the last item
  function automatic bit collect_value(input logic [gcws_pkg::VALUE_BITS-1:0] v,
                                       input logic last, output selection_t res);
    int pos;
    pos = 0;
    if (set_items >= gcws_pkg::MAX_ITEMS) begin
      set_dropped = 1'b1;
    end else begin
      while (pos < set_values.size() && set_values[pos] < v) pos++;
      if (pos < set_values.size() && set_values[pos] == v) begin
        set_counts[pos]++;
      end else begin
        set_values.insert(pos, v);
        set_counts.insert(pos, 1);
      end
      set_items++;
    end
    if (!last) return 0;
    res.total = best_selection();
    res.ovf   = set_dropped;
    set_values.delete();
    set_counts.delete();
    set_items   = 0;
    set_dropped = 1'b0;
    return 1;
  endfunction

  // Offer one value and wait for its transaction; typed rows override the predictor
  task automatic send_value(input logic [gcws_pkg::VALUE_BITS-1:0] v, input logic last,
                            input logic typed = 1'b0,
                            input logic [gcws_pkg::TOTAL_BITS-1:0] t_total = '0,
                            input logic t_ovf = 1'b0);
    selection_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (collect_value(v, last, res)) begin
      if (typed) begin
        res.total = t_total;
        res.ovf   = t_ovf;
      end
      pending_totals.insert(pending_totals.size(), res);
    end
  endtask

  // Block idle: all results in, then let it settle before a register write
  task automatic write_span(input logic [gcws_pkg::SPAN_BITS-1:0] span);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_totals.size() == 0);
    repeat (20) @(negedge clk);
    wait (s_axis_tready);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= span;
    @(negedge clk);
    cfg_we   <= 1'b0;
    span_now  = span;
  endtask

  // One set of random size and content; len returns the number of items sent
  task automatic send_random_set(input int max_len, output int len);
    int mode;
    logic [gcws_pkg::VALUE_BITS-1:0] v;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7)      v = $urandom_range(0, 3 * span_now + 12);
      else if (mode < 9) v = $urandom;
      else               v = 32'hFFFF_FF00 | $urandom_range(0, 255);
      send_value(v, i == len - 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Result check on every output transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result total=%0d ovf=%0b", $realtime,
                 m_axis_tdata[gcws_pkg::TOTAL_BITS-1:0], m_axis_tuser);
        fail_count++;
      end else begin
        if (m_axis_tdata !== {6'd0, pending_totals[0].total}) begin
          $display("%0t: best_total expected %0d actual %0d (tdata %h)", $realtime,
                   pending_totals[0].total, m_axis_tdata[gcws_pkg::TOTAL_BITS-1:0],
                   m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== pending_totals[0].ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $realtime,
                   pending_totals[0].ovf, m_axis_tuser);
          fail_count++;
        end
        void'(pending_totals.pop_front());
      end
    end
  end

  initial begin
    #1ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Directed sets; totals typed where they are obvious
  stim_row_t directed[20] = '{
    '{32'd0,          1'b1, 1'b1, 42'd0,          1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b1, 42'hFFFF_FFFF,  1'b0},
    '{32'd1,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd2,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd3,          1'b1, 1'b0, 42'd0,          1'b0},
    '{32'd2,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd2,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd3,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd3,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd3,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd4,          1'b1, 1'b0, 42'd0,          1'b0},
    '{32'd5,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd8,          1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd5,          1'b1, 1'b0, 42'd0,          1'b0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0, 42'd0,          1'b0},
    '{32'hFFFF_FFFE,  1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd0,          1'b1, 1'b0, 42'd0,          1'b0},
    '{32'd10,         1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd13,         1'b0, 1'b0, 42'd0,          1'b0},
    '{32'd12,         1'b1, 1'b0, 42'd0,          1'b0}
  };

  logic [gcws_pkg::SPAN_BITS-1:0] phase_span[5];

  initial begin
    int sent_len;
    int sent_total;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    set_items     = 0;
    set_dropped   = 1'b0;
    span_now      = gcws_pkg::SPAN_RESET;
    fail_count    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_value(directed[i].value, directed[i].last, directed[i].typed,
                 directed[i].total, directed[i].ovf);

    phase_span[0] = 8'd0;
    phase_span[1] = 8'd255;
    phase_span[2] = 8'($urandom_range(1, 5));
    phase_span[3] = 8'($urandom);
    phase_span[4] = gcws_pkg::SPAN_RESET;
    for (int p = 0; p < 5; p++) begin
      write_span(phase_span[p]);
      if (p == 4) quiet = 1'b1;
      if (p == 1) begin
        // Output held off: results pile up and the input stalls
        hold_req = 1'b1;
        for (int s = 0; s < 4; s++) send_random_set(8, sent_len);
      end
      sent_total = 0;
      while (sent_total < 105) begin
        send_random_set(24, sent_len);
        sent_total += sent_len;
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_totals.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gcws_pkg.sv
sv/gcws_ram.sv
sv/gap_constrained_weight_selection.sv
dv/tb_gap_constrained_weight_selection.sv
